### rtl/identity_record_crc32_builder_assert.svh
// Assertion macros used by the identity record builder back end.
`ifndef IDENTITY_RECORD_CRC32_BUILDER_ASSERT_SVH
`define IDENTITY_RECORD_CRC32_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is held.
`define IDREC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define IDREC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define IDREC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IDREC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/idrec_pkg.sv
// Package with the record layout constants, header type and CRC helpers.
`timescale 1ns / 1ps

package idrec_pkg;

    // Record layout constants.
    localparam logic [31:0] MAGIC_WORD   = 32'h4449_5252;
    localparam logic [7:0]  FORMAT_CODE  = 8'h01;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [7:0]  MARK_SET     = 8'h00;
    localparam logic [47:0] FILL_TAIL    = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] FILL_WORD    = 64'hFFFF_FFFF_FFFF_FFFF;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;

    // Sizes.
    localparam int RECORD_BYTES_DEF      = 256;
    localparam int MAX_WORDS             = 32;
    localparam int ID_BYTES              = 16;
    localparam int HEAD_WORDS            = 4;
    localparam int IDX_W                 = 6;

    // One identifier with its finished checksum, as it sits in the queue.
    typedef struct packed {
        logic [63:0] id_low;
        logic [63:0] id_high;
        logic        committed;
        logic [31:0] crc;
    } t_hdr;

    // Advance the CRC register over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // CRC register after the fixed magic and format bytes.
    function automatic logic [31:0] crc_seed();
        logic [31:0] c;
        c = CRC_ONES;
        c = crc_byte(c, MAGIC_WORD[7:0]);
        c = crc_byte(c, MAGIC_WORD[15:8]);
        c = crc_byte(c, MAGIC_WORD[23:16]);
        c = crc_byte(c, MAGIC_WORD[31:24]);
        c = crc_byte(c, FORMAT_CODE);
        return c;
    endfunction

    localparam logic [31:0] CRC_SEED = crc_seed();

endpackage

### rtl/idrec_front.sv
// Front end: takes identifier words and runs the CRC one byte per cycle.
`timescale 1ns / 1ps

module idrec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [63:0]       i_id_low,
    input  logic [63:0]       i_id_high,
    input  logic              i_committed,
    output logic              o_push,
    input  logic              i_push_ready,
    output idrec_pkg::t_hdr   o_hdr
);

    localparam int CNT_W = $clog2(idrec_pkg::ID_BYTES);

    logic [127:0]     r_id;
    logic             r_commit;
    logic [31:0]      r_crc, n_crc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [7:0]       w_byte;
    logic             w_take;

    // A word is taken when idle, or in the cycle the finished one leaves.
    assign o_ready = !r_busy || (r_done && i_push_ready);
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_done;

    // Identifier byte for this cycle, byte 0 of id_low first.
    assign w_byte = r_id[{r_cnt, 3'b000} +: 8];
    assign n_crc  = idrec_pkg::crc_byte(r_crc, w_byte);

    assign o_hdr.id_low    = r_id[63:0];
    assign o_hdr.id_high   = r_id[127:64];
    assign o_hdr.committed = r_commit;
    assign o_hdr.crc       = r_crc ^ idrec_pkg::CRC_ONES;

    // Control: load, step through sixteen bytes, hand over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_done && i_push_ready) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy && !r_done) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(idrec_pkg::ID_BYTES - 1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Payload and CRC register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_id     <= {i_id_high, i_id_low};
            r_commit <= i_committed;
            r_crc    <= idrec_pkg::CRC_SEED;
        end else if (r_busy && !r_done) begin
            r_crc <= n_crc;
        end
    end

endmodule

### rtl/idrec_queue.sv
// Two-entry queue of finished headers between the front and back ends.
`timescale 1ns / 1ps

module idrec_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_ready,
    input  idrec_pkg::t_hdr   i_hdr,
    output logic              o_valid,
    input  logic              i_pop,
    output idrec_pkg::t_hdr   o_hdr
);

    idrec_pkg::t_hdr r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_fill;
    logic            w_wr;
    logic            w_rd;

    assign o_push_ready = (r_fill != 2'd2);
    assign o_valid      = (r_fill != 2'd0);
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;
    assign o_hdr        = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_hdr;
        end
    end

endmodule

### rtl/idrec_back.sv
// Back end: expands one header into the record words behind an output register.
`timescale 1ns / 1ps
`include "identity_record_crc32_builder_assert.svh"

module idrec_back #(
    parameter int RECORD_BYTES = idrec_pkg::RECORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  idrec_pkg::t_hdr             i_hdr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_record_word,
    output logic [idrec_pkg::IDX_W-1:0] o_word_index,
    output logic                        o_last_word
);

    localparam int RAW_WORDS   = (RECORD_BYTES + 7) / 8;
    localparam int TOTAL_WORDS = (RAW_WORDS > idrec_pkg::MAX_WORDS) ?
                                 idrec_pkg::MAX_WORDS : RAW_WORDS;
    localparam int CW          = $clog2(TOTAL_WORDS);

    idrec_pkg::t_hdr         r_hdr;
    logic                    r_active;
    logic [CW-1:0]           r_cnt;
    logic                    r_out_valid;
    logic [63:0]             r_out_word;
    logic [idrec_pkg::IDX_W-1:0] r_out_idx;
    logic                    r_out_last;
    logic                    w_adv;
    logic                    w_last;
    logic                    w_head;
    logic [255:0]            w_rec;
    logic [63:0]             w_word;

    // The output register may load when empty or being drained.
    assign w_adv   = r_active && (!r_out_valid || i_ready);
    assign w_last  = (r_cnt == CW'(TOTAL_WORDS - 1));
    assign o_q_pop = i_q_valid && (!r_active || (w_adv && w_last));

    // First four words of the record; the rest are all fill.
    assign w_rec = {idrec_pkg::FILL_TAIL,
                    (r_hdr.committed ? idrec_pkg::MARK_SET : idrec_pkg::FILL_BYTE),
                    r_hdr.crc, r_hdr.id_high, r_hdr.id_low,
                    idrec_pkg::FORMAT_CODE, idrec_pkg::MAGIC_WORD};
    assign w_head = (32'(r_cnt) < 32'(idrec_pkg::HEAD_WORDS));
    assign w_word = w_head ? w_rec[{r_cnt[1:0], 6'd0} +: 64] : idrec_pkg::FILL_WORD;

    // Word sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_q_pop) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (w_adv) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_hdr <= i_hdr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= w_word;
            r_out_idx  <= idrec_pkg::IDX_W'(r_cnt);
            r_out_last <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_record_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

    // The final word always carries the last position of the record.
    `IDREC_ASSERT(a_last_idx, i_clk, i_rst_n,
        (r_out_valid && r_out_last) |-> (r_out_idx == idrec_pkg::IDX_W'(TOTAL_WORDS - 1)),
        "last word at wrong index")
    // Inside a record the next word follows at once with the next index.
    `IDREC_ASSERT(a_next_word, i_clk, i_rst_n,
        (r_out_valid && i_ready && !r_out_last) |=>
            (r_out_valid && (r_out_idx == $past(r_out_idx) + 1'b1)),
        "record words not contiguous")
    // A new header is taken only when the previous record is finished.
    `IDREC_ASSERT(a_pop_clean, i_clk, i_rst_n,
        (o_q_pop && r_active) |-> (w_adv && w_last),
        "header popped mid-record")

endmodule

### rtl/identity_record_crc32_builder.sv
// Top level of the identity record builder with CRC-32 framing.
`timescale 1ns / 1ps

// Each accepted word carries a 16-byte identifier and a committed flag and
// yields one flash record of RECORD_BYTES bytes, sent as min(ceil(RECORD_BYTES/8), 32)
// little-endian 64-bit words with the record position and a last flag. The
// record holds the magic bytes, format 1, the identifier, the reflected CRC-32
// over bytes 0-20 and the valid marker; all other bytes are 0xFF. The front end
// runs the CRC one byte per cycle over the 16 identifier bytes, the back end sends
// one word per cycle while i_ready is high, and a two-entry header queue sits
// between them, so a new identifier can be taken while earlier records are still
// being sent, but not while the front end is still checksumming the last one.
// Each header passes the queue, then the back end registers out its record words.
module identity_record_crc32_builder #(
    parameter int RECORD_BYTES = idrec_pkg::RECORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [63:0]                 i_id_low,
    input  logic [63:0]                 i_id_high,
    input  logic                        i_committed,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_record_word,
    output logic [idrec_pkg::IDX_W-1:0] o_word_index,
    output logic                        o_last_word
);

    idrec_pkg::t_hdr w_push_hdr;
    idrec_pkg::t_hdr w_pop_hdr;
    logic            w_push;
    logic            w_push_ready;
    logic            w_q_valid;
    logic            w_q_pop;

    // Front end: capture and checksum.
    idrec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_id_low     (i_id_low),
        .i_id_high    (i_id_high),
        .i_committed  (i_committed),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_hdr        (w_push_hdr)
    );

    // Header queue.
    idrec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_hdr        (w_push_hdr),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_hdr        (w_pop_hdr)
    );

    // Back end: record word generation.
    idrec_back #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_hdr         (w_pop_hdr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_record_word (o_record_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
